>>> rtl/wpe_pkg.sv
// Package for the WS2812 pulse encoder: widths, register indexes and the
// transaction, queue entry and configuration struct types.
// Depends on nothing; every other file of the block imports it.
package wpe_pkg;

   // Width of every duration field and duration register.
   localparam int DURATION_BITS = 15;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = DURATION_BITS;

   // Brightness value that leaves the colour byte unscaled.
   localparam logic [7:0] BRIGHTNESS_FULL = 8'hff;

   // Pulse items per colour byte, and the bit counter that walks them.
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_BITS  = 4;
   localparam logic [BIT_CNT_BITS-1:0] CNT_LAST_BIT = BIT_CNT_BITS'(BITS_PER_BYTE - 1);
   localparam logic [BIT_CNT_BITS-1:0] CNT_LATCH    = BIT_CNT_BITS'(BITS_PER_BYTE);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_LOW   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ONE_HIGH   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ONE_LOW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LATCH      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BRIGHTNESS = 3'd5;

   typedef struct packed {
      logic [7:0] color_byte;
      logic       frame_end;
   } wpe_req_type;

   typedef struct packed {
      logic [DURATION_BITS-1:0] first_ticks;
      logic                     first_level;
      logic [DURATION_BITS-1:0] second_ticks;
      logic                     second_level;
      logic                     last_of_run;
   } wpe_rsp_type;

   // A scaled byte on its way from the front end to the serializer.
   typedef struct packed {
      logic [7:0] scaled_byte;
      logic       frame_end;
   } wpe_qent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wpe_qstat_type;

   typedef struct packed {
      logic [DURATION_BITS-1:0] zero_high_ticks;
      logic [DURATION_BITS-1:0] zero_low_ticks;
      logic [DURATION_BITS-1:0] one_high_ticks;
      logic [DURATION_BITS-1:0] one_low_ticks;
      logic [DURATION_BITS-1:0] latch_ticks;
      logic [7:0]               brightness;
   } wpe_cfg_type;

endpackage

>>> rtl/wpe_front.sv
// Front end of the WS2812 pulse encoder: accepts colour bytes, applies the
// brightness scale and holds the result until the queue takes it.
// Depends on wpe_pkg.
module wpe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  wpe_pkg::wpe_req_type req_data,
   input  logic [7:0]           brightness,
   output logic                 q_push,
   output wpe_pkg::wpe_qent_type q_data,
   input  logic                 q_full
);
   import wpe_pkg::*;

   logic         valid_ff, valid_in;
   wpe_qent_type ent_ff, ent_in;
   logic         accept;
   logic [15:0]  product;

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_data   = ent_ff;

   assign product = 16'(req_data.color_byte) * 16'(brightness);

   always_comb begin
      ent_in.frame_end = req_data.frame_end;
      if (brightness == BRIGHTNESS_FULL) begin
         ent_in.scaled_byte = req_data.color_byte;
      end else begin
         ent_in.scaled_byte = product[15:8];
      end
      valid_in = accept || (valid_ff && !q_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule

>>> rtl/wpe_queue.sv
// Two-entry queue between the front end and the serializer of the WS2812
// pulse encoder. Depends on wpe_pkg.
module wpe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wpe_pkg::wpe_qent_type push_data,
   input  logic                  pop,
   output wpe_pkg::wpe_qent_type pop_data,
   output wpe_pkg::wpe_qstat_type stat
);
   import wpe_pkg::*;

   wpe_qent_type mem [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign stat.full  = count_ff == 2'd2;
   assign stat.empty = count_ff == 2'd0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/wpe_back.sv
// Serializer of the WS2812 pulse encoder: turns each queued byte into eight pulse
// items and an optional latch item into an output register, one per cycle unless
// the receiver stalls. Depends on wpe_pkg.
module wpe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wpe_pkg::wpe_cfg_type   cfg,
   input  wpe_pkg::wpe_qent_type  q_data,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output wpe_pkg::wpe_rsp_type   rsp_data
);
   import wpe_pkg::*;

   logic                    busy_ff, busy_in;
   logic [7:0]              shift_ff, shift_in;
   logic                    fend_ff, fend_in;
   logic [BIT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    out_valid_ff, out_valid_in;
   wpe_rsp_type             out_ff, item;
   logic                    out_adv, emit, done, is_latch;

   assign out_adv  = !out_valid_ff || rsp_pop;
   assign emit     = busy_ff && out_adv;
   assign is_latch = cnt_ff == CNT_LATCH;
   assign done     = emit && (is_latch || (cnt_ff == CNT_LAST_BIT && !fend_ff));
   assign q_pop    = !q_empty && (!busy_ff || done);

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Item for the current position in the byte.
   always_comb begin
      item.second_level = 1'b0;
      if (is_latch) begin
         item.first_ticks  = cfg.latch_ticks;
         item.first_level  = 1'b0;
         item.second_ticks = '0;
         item.last_of_run  = 1'b1;
      end else begin
         item.first_level = 1'b1;
         item.last_of_run = (cnt_ff == CNT_LAST_BIT) && !fend_ff;
         if (shift_ff[7]) begin
            item.first_ticks  = cfg.one_high_ticks;
            item.second_ticks = cfg.one_low_ticks;
         end else begin
            item.first_ticks  = cfg.zero_high_ticks;
            item.second_ticks = cfg.zero_low_ticks;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      fend_in  = fend_ff;
      cnt_in   = cnt_ff;
      priority if (q_pop) begin
         busy_in  = 1'b1;
         shift_in = q_data.scaled_byte;
         fend_in  = q_data.frame_end;
         cnt_in   = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         shift_in = {shift_ff[6:0], 1'b0};
         cnt_in   = cnt_ff + BIT_CNT_BITS'(1);
      end
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      fend_ff  <= fend_in;
      if (emit) begin
         out_ff <= item;
      end
   end

endmodule

>>> rtl/ws2812_pulse_encoder.sv
// Top level of the WS2812 pulse encoder: configuration registers and the
// front end, queue and serializer. Depends on wpe_pkg, wpe_front, wpe_queue
// and wpe_back.
//
// Usage: each input transaction (req_push while req_full is low) carries one
// colour byte and a frame_end flag. The byte is scaled by the brightness
// register, (byte * brightness) >> 8, unless brightness is 255. It then leaves
// as eight pulse transactions on the rsp_ side, most significant bit first,
// each a high phase and a low phase taken from the one or zero duration
// registers. A byte marked frame_end adds a ninth, latch transaction: low for
// latch_ticks, second duration zero. last_of_run marks each byte's final item.
// The rsp_ side is a queue head: data is valid while rsp_empty is low and is
// taken on rsp_pop.
// When the block is idle, the first pulse item of a byte passes the front end
// register, the queue and the serializer on its way to the output register.
// The serializer produces one pulse item per cycle while the receiver takes
// them, and loads the next byte as it emits the last item of the current one;
// a two-entry queue and the front end register hold the following bytes.
// Reset (synchronous, active high) empties the pipeline and returns the
// registers to their defaults. When the receiver stalls, the output register
// holds its item, the serializer waits, and req_full rises once the queue
// and the front end register are both occupied.
// Registers are written through csr_, by the user only while the block is idle
// (the block does not enforce this); an index beyond the register list is ignored.
module ws2812_pulse_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  wpe_pkg::wpe_req_type                req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output wpe_pkg::wpe_rsp_type                rsp_data,
   input  logic                                csr_write_en,
   input  logic [wpe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wpe_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import wpe_pkg::*;

   wpe_cfg_type   cfg_ff;
   logic          q_push, q_pop;
   wpe_qent_type  q_in, q_out;
   wpe_qstat_type q_stat;

   // Configuration registers. Durations keep the low DURATION_BITS bits of the
   // write data, brightness the low byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_high_ticks <= DURATION_BITS'(16);
         cfg_ff.zero_low_ticks  <= DURATION_BITS'(34);
         cfg_ff.one_high_ticks  <= DURATION_BITS'(32);
         cfg_ff.one_low_ticks   <= DURATION_BITS'(18);
         cfg_ff.latch_ticks     <= DURATION_BITS'(1400);
         cfg_ff.brightness      <= BRIGHTNESS_FULL;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_ZERO_HIGH:  cfg_ff.zero_high_ticks <= csr_wdata[DURATION_BITS-1:0];
            REG_ZERO_LOW:   cfg_ff.zero_low_ticks  <= csr_wdata[DURATION_BITS-1:0];
            REG_ONE_HIGH:   cfg_ff.one_high_ticks  <= csr_wdata[DURATION_BITS-1:0];
            REG_ONE_LOW:    cfg_ff.one_low_ticks   <= csr_wdata[DURATION_BITS-1:0];
            REG_LATCH:      cfg_ff.latch_ticks     <= csr_wdata[DURATION_BITS-1:0];
            REG_BRIGHTNESS: cfg_ff.brightness      <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Front end: accepts and scales bytes.
   wpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .brightness (cfg_ff.brightness),
      .q_push     (q_push),
      .q_data     (q_in),
      .q_full     (q_stat.full)
   );

   // Queue that decouples the front end from the serializer.
   wpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   // Serializer: one pulse item per cycle, unless the receiver stalls, into the output register.
   wpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_data    (q_out),
      .q_empty   (q_stat.empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The queue can never report full and empty at once.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   // A byte pushed into the queue leaves it non-empty in the next cycle.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      q_push |=> !q_stat.empty)
      else $error("queue empty right after a push");

   // A latch item always closes its run and has a zero second phase.
   a_latch_item: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.first_level) |->
         (rsp_data.last_of_run && rsp_data.second_ticks == '0))
      else $error("malformed latch item");

endmodule

>>> test/pulse_check_pkg.sv
`timescale 1ns / 1ps
// Pulse scoreboard for the WS2812 pulse encoder testbench: a mirror of the
// timing registers, the predicted pulse items and the field-by-field check.
// Depends on wpe_pkg for the transaction, configuration and index types.
package pulse_check_pkg;
   import wpe_pkg::*;

   class pulse_scoreboard;
      wpe_cfg_type regs;
      wpe_rsp_type expected_pulses[$];
      int mismatches;
      int bytes_noted;
      int frames_noted;
      int pulses_checked;

      function new();
         regs.zero_high_ticks = DURATION_BITS'(16);
         regs.zero_low_ticks  = DURATION_BITS'(34);
         regs.one_high_ticks  = DURATION_BITS'(32);
         regs.one_low_ticks   = DURATION_BITS'(18);
         regs.latch_ticks     = DURATION_BITS'(1400);
         regs.brightness      = BRIGHTNESS_FULL;
      endfunction

      function void write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                              input logic [CSR_DATA_BITS-1:0] data);
         case (index)
            REG_ZERO_HIGH:  regs.zero_high_ticks = data;
            REG_ZERO_LOW:   regs.zero_low_ticks  = data;
            REG_ONE_HIGH:   regs.one_high_ticks  = data;
            REG_ONE_LOW:    regs.one_low_ticks   = data;
            REG_LATCH:      regs.latch_ticks     = data;
            REG_BRIGHTNESS: regs.brightness      = data[7:0];
            default: ;
         endcase
      endfunction

      // Predicts the eight bit pulses of one accepted byte, plus the latch
      // item when the byte closes a frame.
      function void note_byte(input wpe_req_type item);
         logic [7:0]  scaled;
         logic [15:0] product;
         wpe_rsp_type pulse;
         scaled = item.color_byte;
         if (regs.brightness != BRIGHTNESS_FULL) begin
            product = 16'(item.color_byte) * 16'(regs.brightness);
            scaled  = product[15:8];
         end
         for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
            pulse.first_ticks  = scaled[b] ? regs.one_high_ticks : regs.zero_high_ticks;
            pulse.first_level  = 1'b1;
            pulse.second_ticks = scaled[b] ? regs.one_low_ticks : regs.zero_low_ticks;
            pulse.second_level = 1'b0;
            pulse.last_of_run  = !item.frame_end && (b == 0);
            expected_pulses.push_back(pulse);
         end
         if (item.frame_end) begin
            pulse.first_ticks  = regs.latch_ticks;
            pulse.first_level  = 1'b0;
            pulse.second_ticks = '0;
            pulse.second_level = 1'b0;
            pulse.last_of_run  = 1'b1;
            expected_pulses.push_back(pulse);
            frames_noted++;
         end
         bytes_noted++;
      endfunction

      task report(input string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(input string name, input logic [31:0] got,
                         input logic [31:0] want);
         if (got !== want)
            report($sformatf("pulse %0d %s got %0h want %0h",
                             pulses_checked, name, got, want));
      endtask

      task check_pulse(input wpe_rsp_type got);
         wpe_rsp_type want;
         if (expected_pulses.size() == 0) begin
            report($sformatf("unexpected pulse item %p", got));
            return;
         end
         want = expected_pulses.pop_front();
         compare_field("first_ticks", got.first_ticks, want.first_ticks);
         compare_field("first_level", got.first_level, want.first_level);
         compare_field("second_ticks", got.second_ticks, want.second_ticks);
         compare_field("second_level", got.second_level, want.second_level);
         compare_field("last_of_run", got.last_of_run, want.last_of_run);
         pulses_checked++;
      endtask

      task check_leftovers();
         if (expected_pulses.size() != 0)
            report($sformatf("%0d pulse items never arrived", expected_pulses.size()));
      endtask
   endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of ws2812_pulse_encoder: clock, reset, drivers for the
// input, result and register ports, and the run. Depends on wpe_pkg and on
// pulse_check_pkg for the scoreboard.
module tb_top;
   import wpe_pkg::*;
   import pulse_check_pkg::*;

   // A stall this long lets the queue and the front end register fill up so
   // that req_full has to rise while the sender keeps offering bytes.
   localparam int HOLD_CYCLES    = 300;
   // Cycles allowed after the last expected pulse before the block counts as idle.
   localparam int DRAIN_GRACE    = 6;
   // The slowest correct gap without a transaction is the long hold plus a
   // register update, so a few times that is a safe watchdog bound.
   localparam int WATCHDOG_LIMIT = 2000;

   logic         clock;
   logic         reset;
   logic         req_push;
   logic         req_full;
   wpe_req_type  req_data;
   logic         rsp_empty;
   logic         rsp_pop;
   wpe_rsp_type  rsp_data;
   logic         csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   pulse_scoreboard book = new();

   // The receiver reads its stall pattern one bit per cycle outside a long stall;
   // hold_request asks it for one long stall, which it clears itself when done.
   logic [15:0] pop_pattern;
   logic        hold_request;
   int          long_holds;
   int          settings_used;
   int          stalled_cycles;

   ws2812_pulse_encoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every transaction on either side is seen here at the rising edge. The
   // result check runs before the new byte is noted, although a byte's own
   // pulses can never leave in the cycle it is accepted. The same block
   // keeps the watchdog, which only counts cycles with no transaction.
   always @(posedge clock) begin
      if (reset) begin
         stalled_cycles <= 0;
      end else begin
         if (rsp_pop && !rsp_empty)
            book.check_pulse(rsp_data);
         if (req_push && !req_full)
            book.note_byte(req_data);
         if ((rsp_pop && !rsp_empty) || (req_push && !req_full)) begin
            stalled_cycles <= 0;
         end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            stalled_cycles <= stalled_cycles + 1;
         end
      end
   end

   // Receiver. It changes rsp_pop at the falling edge only. A long hold keeps
   // rsp_pop low for a stall that it counts itself, independent of what the sender
   // does meanwhile.
   initial begin : receiver
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            long_holds++;
         end
         rsp_pop <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
   end

   function automatic wpe_req_type color_item(input logic [7:0] color, input logic fend);
      wpe_req_type item;
      item.color_byte = color;
      item.frame_end  = fend;
      return item;
   endfunction

   // All driving tasks start and end at a falling edge. push_byte leaves
   // req_push high so that a burst can continue straight into the next byte.
   task automatic push_byte(input wpe_req_type item);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // The register mirror is updated at once, which is safe because writes
   // only happen while nothing is in flight.
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      book.write_reg(index, data);
      @(negedge clock);
   endtask

   // Writes all six registers. The brightness word can carry upper bits that
   // the block must drop.
   task automatic set_timings(input logic [CSR_DATA_BITS-1:0] zero_high,
                              input logic [CSR_DATA_BITS-1:0] zero_low,
                              input logic [CSR_DATA_BITS-1:0] one_high,
                              input logic [CSR_DATA_BITS-1:0] one_low,
                              input logic [CSR_DATA_BITS-1:0] latch,
                              input logic [CSR_DATA_BITS-1:0] bright_word);
      csr_write(REG_ZERO_HIGH, zero_high);
      csr_write(REG_ZERO_LOW, zero_low);
      csr_write(REG_ONE_HIGH, one_high);
      csr_write(REG_ONE_LOW, one_low);
      csr_write(REG_LATCH, latch);
      csr_write(REG_BRIGHTNESS, bright_word);
      csr_write_en <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // Waits until every predicted pulse has been taken, then gives the block
   // the DRAIN_GRACE period to settle.
   task automatic wait_for_drain();
      while (book.expected_pulses.size() != 0) @(negedge clock);
      repeat (DRAIN_GRACE) @(negedge clock);
   endtask

   task automatic close_phase();
      req_push <= 1'b0;
      wait_for_drain();
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] random_ticks();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return CSR_DATA_BITS'($urandom_range(0, 32767));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_bright_word();
      logic [7:0] level;
      case ($urandom_range(0, 9))
         0, 1:    level = BRIGHTNESS_FULL;
         2:       level = 8'h00;
         default: level = 8'($urandom_range(0, 255));
      endcase
      return CSR_DATA_BITS'({7'($urandom_range(0, 127)), level});
   endfunction

   task automatic random_settings();
      set_timings(random_ticks(), random_ticks(), random_ticks(), random_ticks(),
                  random_ticks(), random_bright_word());
   endtask

   // Random frames: mostly well-formed frames of 1 to 12 bytes with the
   // flag on the last byte, with about one byte in ten getting its flag
   // flipped. The sender works in bursts of 1 to 12 bytes separated by gaps
   // bounded by max_gap. Optionally one long receiver hold starts a
   // third of the way in, and the sender pauses for a full drain two thirds
   // of the way in.
   task automatic random_frames(input int count, input int max_gap,
                                input bit with_hold, input bit with_pause);
      int          frame_left;
      int          burst_left;
      int          gap;
      bit          pause;
      wpe_req_type item;
      frame_left = 0;
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < count; k++) begin
         if (frame_left == 0)
            frame_left = $urandom_range(1, 12);
         case ($urandom_range(0, 7))
            0:       item.color_byte = 8'h00;
            1:       item.color_byte = 8'hff;
            default: item.color_byte = 8'($urandom_range(0, 255));
         endcase
         item.frame_end = (frame_left == 1);
         if ($urandom_range(0, 9) == 0)
            item.frame_end = !item.frame_end;
         frame_left--;

         pause = with_pause && (k == (2 * count) / 3);
         gap = 0;
         if (k > 0) begin
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               if (max_gap > 0)
                  gap = $urandom_range(0, max_gap);
            end
         end
         if (pause && gap == 0)
            gap = 1;
         if (gap > 0) begin
            req_push <= 1'b0;
            if (pause)
               wait_for_drain();
            repeat (gap) @(negedge clock);
         end
         if (with_hold && k == count / 3)
            hold_request = 1'b1;
         push_byte(item);
      end
      close_phase();
   endtask

   initial begin : stimulus
      reset        = 1'b1;
      req_push     = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      hold_request = 1'b0;
      pop_pattern  = 16'hffff;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing, no scaling: all-zero and all-one bytes and the two
      // alternating patterns, with and without a frame end.
      push_byte(color_item(8'h00, 1'b0));
      push_byte(color_item(8'hff, 1'b0));
      push_byte(color_item(8'ha5, 1'b1));
      push_byte(color_item(8'h5a, 1'b1));
      close_phase();

      // Opposite duration extremes for zero and one bits, the longest latch,
      // and a brightness word whose upper bits must be ignored (scale 0x80).
      pop_pattern = 16'h5555;
      set_timings('0, '1, '1, '0, '1, 15'h7f80);
      push_byte(color_item(8'hff, 1'b0));
      push_byte(color_item(8'h80, 1'b0));
      push_byte(color_item(8'h01, 1'b0));
      push_byte(color_item(8'hfe, 1'b1));
      close_phase();

      // The other extremes, zero latch, zero brightness. The writes to the
      // two indexes past the register list must leave everything unchanged.
      pop_pattern = 16'hffff;
      set_timings('1, '0, '0, '1, '0, 15'h0000);
      csr_write(3'd6, '1);
      csr_write(3'd7, '1);
      csr_write_en <= 1'b0;
      @(negedge clock);
      push_byte(color_item(8'hff, 1'b1));
      push_byte(color_item(8'h12, 1'b0));
      close_phase();

      // Brightness one below full scale still scales.
      set_timings(15'h0155, 15'h02aa, 15'h4321, 15'h1234, 15'h0abc, 15'h00fe);
      push_byte(color_item(8'hff, 1'b0));
      push_byte(color_item(8'h01, 1'b0));
      push_byte(color_item(8'h80, 1'b1));
      close_phase();

      // Smallest nonzero brightness crushes even a full byte to zero.
      set_timings(15'h2aaa, 15'h5555, 15'h0001, 15'h7ffe, 15'h0400, 15'h0001);
      push_byte(color_item(8'hff, 1'b0));
      push_byte(color_item(8'h7f, 1'b1));
      close_phase();

      // Random part. The first and last phases carry a long receiver hold under
      // bursty input; the second and third pause once for a full drain, the second
      // streaming without gaps or stalls; the third mixes gaps with random stalls, the last with sparse popping.
      random_settings();
      pop_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
      random_frames(45, 6, 1'b1, 1'b0);

      random_settings();
      pop_pattern = 16'hffff;
      random_frames(45, 0, 1'b0, 1'b1);

      random_settings();
      pop_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
      random_frames(45, 3, 1'b0, 1'b1);

      random_settings();
      pop_pattern = 16'h0101;
      random_frames(45, 8, 1'b1, 1'b0);

      repeat (10) @(posedge clock);
      book.check_leftovers();
      $display("Run covered %0d bytes in %0d frames and %0d checked pulse items under %0d settings.",
               book.bytes_noted, book.frames_noted, book.pulses_checked, settings_used);
      $display("It included %0d long output stalls with the input backed up, plus drained pauses.",
               long_holds);
      if (book.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
